@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/asc_pkg.sv @@
// Shared types and decision codes for the angular sector compatibility block.
`timescale 1ns / 1ps

package asc_pkg;

    // Which rule settled the result.
    typedef enum logic [2:0] {
        DEC_IDENTICAL = 3'd0,
        DEC_SWAPPED   = 3'd1,
        DEC_SHARED    = 3'd2,
        DEC_CROSS     = 3'd3,
        DEC_AREA      = 3'd4
    } decide_t;

    // Point equalities between the two sectors.
    typedef struct packed {
        logic s1s2;
        logic s1e2;
        logic e1s2;
        logic e1e2;
    } match_t;

    // Outcome of one chord pair test.
    typedef struct packed {
        logic nonpar;
        logic s_inside;
        logic t_inside;
    } cross_t;

endpackage

@@ design/asc_chord_cross.sv @@
// Four-stage pipelined strict crossing test for one pair of chords.
`timescale 1ns / 1ps

module asc_chord_cross #(
    parameter int DW = 17
) (
    input  logic                 clk,
    input  logic signed [DW-1:0] qx,
    input  logic signed [DW-1:0] qy,
    input  logic signed [DW-1:0] px,
    input  logic signed [DW-1:0] py,
    input  logic signed [DW-1:0] vx,
    input  logic signed [DW-1:0] vy,
    output asc_pkg::cross_t      result
);

    localparam int PW = 2 * DW;
    localparam int DTW = PW + 1;

    logic signed [PW-1:0]  qxpy_reg, qypx_reg, qxvy_reg, qyvx_reg, pyvx_reg, pxvy_reg;
    logic signed [DTW-1:0] d_reg, sn_reg, tn_reg;
    logic signed [DTW-1:0] d_next, sn_next, tn_next;
    logic signed [DTW-1:0] absd_reg, s_reg, t_reg;
    logic signed [DTW-1:0] absd_next, s_next, t_next;
    logic                  nonpar_reg;
    asc_pkg::cross_t       result_reg, result_next;

    // Stage three: the three determinants.
    always_comb
    begin
        d_next  = DTW'(qxpy_reg) - DTW'(qypx_reg);
        sn_next = DTW'(qxvy_reg) - DTW'(qyvx_reg);
        tn_next = DTW'(pyvx_reg) - DTW'(pxvy_reg);
    end

    // Stage four: fold the sign of the denominator into both numerators.
    always_comb
    begin
        absd_next = d_reg[DTW-1] ? -d_reg : d_reg;
        s_next    = (d_reg > 0) ? -sn_reg : sn_reg;
        t_next    = d_reg[DTW-1] ? -tn_reg : tn_reg;
    end

    // Stage five: both parameters must lie strictly inside the chords.
    always_comb
    begin
        result_next.nonpar   = nonpar_reg;
        result_next.s_inside = (s_reg > 0) && (s_reg < absd_reg);
        result_next.t_inside = (t_reg > 0) && (t_reg < absd_reg);
    end

    always_ff @(posedge clk)
    begin
        qxpy_reg   <= qx * py;
        qypx_reg   <= qy * px;
        qxvy_reg   <= qx * vy;
        qyvx_reg   <= qy * vx;
        pyvx_reg   <= py * vx;
        pxvy_reg   <= px * vy;
        d_reg      <= d_next;
        sn_reg     <= sn_next;
        tn_reg     <= tn_next;
        absd_reg   <= absd_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        nonpar_reg <= (d_reg != '0);
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

@@ design/angular_sector_compatibility.sv @@
// Top level of the angular sector compatibility pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Decides whether two angular sectors, each given by the direction vectors of
// its start and end rays, can sit side by side at a common vertex.
// A beat is accepted at a rising edge where start is high and busy is low.
// The block never stalls, so busy is always low and a new beat may be offered
// in every cycle; one beat enters per clock and one result leaves per clock.
// The work runs through six register stages: differences and point
// equalities, products, determinants, sign folding and area sum, the strict
// interior compares, and the final decision. The multiplier stage sets the
// clock; the pipeline depth sets the latency.
// The result of a beat sits on compatible and decided_by for exactly one cycle,
// marked by done, once it has left the final decision stage. Results come out
// in the order the beats went in.
// The receiver cannot stall, so there is no back pressure to handle.
// An asynchronous low on rst_n empties the pipeline: every valid bit clears
// and done stays low until new beats have travelled through.
// Coordinates are COORD_WIDTH bits, two's complement; all geometry is exact.
module angular_sector_compatibility #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] start1_x,
    input  logic signed [COORD_WIDTH-1:0] start1_y,
    input  logic signed [COORD_WIDTH-1:0] end1_x,
    input  logic signed [COORD_WIDTH-1:0] end1_y,
    input  logic signed [COORD_WIDTH-1:0] start2_x,
    input  logic signed [COORD_WIDTH-1:0] start2_y,
    input  logic signed [COORD_WIDTH-1:0] end2_x,
    input  logic signed [COORD_WIDTH-1:0] end2_y,
    output logic                          done,
    output logic                          compatible,
    output logic [2:0]                    decided_by
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;      // coordinate differences
    localparam int MW  = 2 * W;      // area products
    localparam int TW  = MW + 1;     // one shoelace term
    localparam int AW  = MW + 3;     // sum of four terms
    localparam int NST = 6;          // register stages

    // The pipeline never holds off a beat.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits, one per stage; bit NST-1 is the output stage.
    logic [NST-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], accept};
        end
    end

    // Stage one: sign-extended differences for both chord pairs and the
    // point equalities. Coordinates are kept for the area products.
    logic signed [DW-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;

    assign s1x = DW'(start1_x);
    assign s1y = DW'(start1_y);
    assign e1x = DW'(end1_x);
    assign e1y = DW'(end1_y);
    assign s2x = DW'(start2_x);
    assign s2y = DW'(start2_y);
    assign e2x = DW'(end2_x);
    assign e2y = DW'(end2_y);

    logic signed [W-1:0]  c_s1x_reg, c_s1y_reg, c_e1x_reg, c_e1y_reg;
    logic signed [W-1:0]  c_s2x_reg, c_s2y_reg, c_e2x_reg, c_e2y_reg;
    logic signed [DW-1:0] qax_reg, qay_reg, pax_reg, pay_reg;
    logic signed [DW-1:0] qbx_reg, qby_reg, pbx_reg, pby_reg;
    logic signed [DW-1:0] vx_reg, vy_reg;
    asc_pkg::match_t      match_next;
    asc_pkg::match_t      match_reg [NST-1];

    always_comb
    begin
        match_next.s1s2 = (start1_x == start2_x) && (start1_y == start2_y);
        match_next.s1e2 = (start1_x == end2_x)   && (start1_y == end2_y);
        match_next.e1s2 = (end1_x == start2_x)   && (end1_y == start2_y);
        match_next.e1e2 = (end1_x == end2_x)     && (end1_y == end2_y);
    end

    always_ff @(posedge clk)
    begin
        c_s1x_reg <= start1_x;
        c_s1y_reg <= start1_y;
        c_e1x_reg <= end1_x;
        c_e1y_reg <= end1_y;
        c_s2x_reg <= start2_x;
        c_s2y_reg <= start2_y;
        c_e2x_reg <= end2_x;
        c_e2y_reg <= end2_y;
        // Chord S1-E2 against chord S2-E1.
        qax_reg   <= e1x - s2x;
        qay_reg   <= e1y - s2y;
        pax_reg   <= e2x - s1x;
        pay_reg   <= e2y - s1y;
        // Chord S1-E1 against chord S2-E2.
        qbx_reg   <= e2x - s2x;
        qby_reg   <= e2y - s2y;
        pbx_reg   <= e1x - s1x;
        pby_reg   <= e1y - s1y;
        // Both tests start from S1 relative to S2.
        vx_reg    <= s1x - s2x;
        vy_reg    <= s1y - s2y;
        match_reg[0] <= match_next;
        for (int i = 1; i < NST - 1; i++)
        begin
            match_reg[i] <= match_reg[i-1];
        end
    end

    // Stages two to five of both crossing tests.
    asc_pkg::cross_t cross_a, cross_b;

    asc_chord_cross #(
        .DW (DW)
    ) u_cross_a (
        .clk    (clk),
        .qx     (qax_reg),
        .qy     (qay_reg),
        .px     (pax_reg),
        .py     (pay_reg),
        .vx     (vx_reg),
        .vy     (vy_reg),
        .result (cross_a)
    );

    asc_chord_cross #(
        .DW (DW)
    ) u_cross_b (
        .clk    (clk),
        .qx     (qbx_reg),
        .qy     (qby_reg),
        .px     (pbx_reg),
        .py     (pby_reg),
        .vx     (vx_reg),
        .vy     (vy_reg),
        .result (cross_b)
    );

    // Shoelace area of S1, E1, S2, E2 on the same stage schedule.
    logic signed [MW-1:0] ap_reg [8];
    logic signed [TW-1:0] at_reg [4];
    logic signed [AW-1:0] asum_reg, asum_next;
    logic                 apos_reg;

    assign asum_next = AW'(at_reg[0]) + AW'(at_reg[1]) + AW'(at_reg[2]) + AW'(at_reg[3]);

    always_ff @(posedge clk)
    begin
        ap_reg[0] <= c_s1x_reg * c_e1y_reg;
        ap_reg[1] <= c_e1x_reg * c_s1y_reg;
        ap_reg[2] <= c_e1x_reg * c_s2y_reg;
        ap_reg[3] <= c_s2x_reg * c_e1y_reg;
        ap_reg[4] <= c_s2x_reg * c_e2y_reg;
        ap_reg[5] <= c_e2x_reg * c_s2y_reg;
        ap_reg[6] <= c_e2x_reg * c_s1y_reg;
        ap_reg[7] <= c_s1x_reg * c_e2y_reg;
        for (int i = 0; i < 4; i++)
        begin
            at_reg[i] <= TW'(ap_reg[2*i]) - TW'(ap_reg[2*i+1]);
        end
        asum_reg <= asum_next;
        apos_reg <= !asum_reg[AW-1] && (asum_reg != '0);
    end

    // Stage six: apply the rules in priority order.
    asc_pkg::match_t  m5;
    logic             crosses;
    logic             comp_next, comp_reg;
    asc_pkg::decide_t dec_next, dec_reg;

    assign m5      = match_reg[NST-2];
    assign crosses = (cross_a.nonpar && cross_a.s_inside && cross_a.t_inside) ||
                     (cross_b.nonpar && cross_b.s_inside && cross_b.t_inside);

    always_comb
    begin
        if (m5.s1s2 && m5.e1e2)
        begin
            comp_next = 1'b0;
            dec_next  = asc_pkg::DEC_IDENTICAL;
        end
        else if (m5.s1e2 && m5.e1s2)
        begin
            comp_next = 1'b1;
            dec_next  = asc_pkg::DEC_SWAPPED;
        end
        else if (m5.s1s2 || m5.s1e2 || m5.e1s2 || m5.e1e2)
        begin
            comp_next = apos_reg;
            dec_next  = asc_pkg::DEC_SHARED;
        end
        else if (crosses)
        begin
            comp_next = 1'b0;
            dec_next  = asc_pkg::DEC_CROSS;
        end
        else
        begin
            comp_next = apos_reg;
            dec_next  = asc_pkg::DEC_AREA;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg <= comp_next;
        dec_reg  <= dec_next;
    end

    assign done       = vld_reg[NST-1];
    assign compatible = comp_reg;
    assign decided_by = dec_reg;

    // A result decided by a rule that fixes the answer on its own.
    logic fixed_rule;
    assign fixed_rule = done && (decided_by == asc_pkg::DEC_IDENTICAL ||
                                 decided_by == asc_pkg::DEC_SWAPPED ||
                                 decided_by == asc_pkg::DEC_CROSS);

    // Every accepted beat yields its result after the fixed pipeline depth.
    `ASSERT_IMPL(a_latency, accept, ##6 done)
    // No result appears without a beat accepted one pipeline depth earlier.
    `ASSERT_IMPL(a_no_spurious, done, $past(accept, 6))
    // Rules that fix the answer must agree with it.
    `ASSERT_IMPL(a_fixed_rules, fixed_rule, compatible == (decided_by == asc_pkg::DEC_SWAPPED))

endmodule
